// ===== hw/rtl/crn_pkg.sv =====
`default_nettype none

package crn_pkg;

    // Fixed network output size
    localparam int OUT_W = 192;
    localparam int OUT_H = 256;

    // Default frame store geometry
    localparam int FRAME_MAX_W_DEF = 512;
    localparam int FRAME_MAX_H_DEF = 512;

    // Configuration port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // floor(a / 3) = (a * RECIP3) >> RECIP3_SH for a below 2^23
    localparam logic [23:0] RECIP3    = 24'd11184811;
    localparam int          RECIP3_SH = 25;

    // Channel statistics, scaled by 1000
    localparam longint MEAN_R = 123675;
    localparam longint MEAN_G = 116280;
    localparam longint MEAN_B = 103530;
    localparam longint SD_R   = 58395;
    localparam longint SD_G   = 57120;
    localparam longint SD_B   = 57375;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_W  = 3'd0,
        REG_FRAME_H  = 3'd1,
        REG_CROP_CX  = 3'd2,
        REG_CROP_CY  = 3'd3,
        REG_CROP_W   = 3'd4,
        REG_CROP_H   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [9:0]         frame_w;
        logic [9:0]         frame_h;
        logic signed [20:0] ccx;
        logic signed [20:0] ccy;
        logic [20:0]        cw;
        logic [20:0]        chh;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        frame_w: 10'd512,
        frame_h: 10'd512,
        ccx:     21'sd262144,
        ccy:     21'sd262144,
        cw:      21'd196608,
        chh:     21'd262144
    };

    // Sample position handed from the coordinate pipe to the store
    typedef struct packed {
        logic               v;
        logic               wr;
        logic [8:0]         cx;
        logic [8:0]         cy;
        logic [23:0]        rgb;
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic [4:0]         fx;
        logic [4:0]         fy;
    } t_pos;

    // Four neighbours with their weights, one per bank
    typedef struct packed {
        logic             v;
        logic [7:0]       ox;
        logic [7:0]       oy;
        logic [3:0][10:0] w;
        logic [3:0][23:0] pix;
    } t_tap;

    typedef struct packed {
        logic [7:0]         out_x;
        logic [7:0]         out_y;
        logic signed [15:0] red_norm;
        logic signed [15:0] green_norm;
        logic signed [15:0] blue_norm;
    } t_res;

    typedef logic signed [15:0] t_lut [256];

    // Normalisation table per channel, evaluated at elaboration
    function automatic t_lut build_lut(input int ch);
        t_lut   lut;
        longint n;
        longint q;
        for (int v = 0; v < 256; v++) begin
            case (ch)
                0: begin
                    n = 4096 * (1000 * longint'(v) - MEAN_R);
                    q = (n >= 0) ? (2 * n + SD_R) / (2 * SD_R)
                                 : -((-2 * n + SD_R) / (2 * SD_R));
                end
                1: begin
                    n = 4096 * (1000 * longint'(v) - MEAN_G);
                    q = (n >= 0) ? (2 * n + SD_G) / (2 * SD_G)
                                 : -((-2 * n + SD_G) / (2 * SD_G));
                end
                default: begin
                    n = 4096 * (1000 * longint'(v) - MEAN_B);
                    q = (n >= 0) ? (2 * n + SD_B) / (2 * SD_B)
                                 : -((-2 * n + SD_B) / (2 * SD_B));
                end
            endcase
            if (q > 32767) begin
                q = 32767;
            end
            if (q < -32768) begin
                q = -32768;
            end
            lut[v] = 16'(q);
        end
        return lut;
    endfunction

    localparam t_lut NORM_LUT_R = build_lut(0);
    localparam t_lut NORM_LUT_G = build_lut(1);
    localparam t_lut NORM_LUT_B = build_lut(2);

endpackage

`default_nettype wire

// ===== hw/rtl/crn_if.sv =====
`default_nettype none

// Input item channel
interface crn_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [8:0] coord_x;
    logic [8:0] coord_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, func, coord_x, coord_y, red, green, blue, input ready);
    modport sink   (input valid, func, coord_x, coord_y, red, green, blue, output ready);
endinterface

// Result channel
interface crn_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         out_x;
    logic [7:0]         out_y;
    logic signed [15:0] red_norm;
    logic signed [15:0] green_norm;
    logic signed [15:0] blue_norm;
    modport source (output valid, out_x, out_y, red_norm, green_norm, blue_norm,
                    input ready);
    modport sink   (input valid, out_x, out_y, red_norm, green_norm, blue_norm,
                    output ready);
endinterface

// Register write channel
interface crn_cfg_if;
    import crn_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bilinear_crop_resize_normalize_top.sv =====
// Compute beats pass coordinate stages, store read, weighted sum, output register.
// Throughput: one beat per cycle, writes and computes mixed freely; each output
// pixel reads one entry from each of four parity banks of the frame store.
// The whole pipeline holds while a result waits at the output register.
// Reset (synchronous, active low) restores register defaults and empties the
// pipeline; the frame store is not cleared and reads undefined until written.
`default_nettype none

module bilinear_crop_resize_normalize_top #(
    parameter int FRAME_MAX_W = crn_pkg::FRAME_MAX_W_DEF,
    parameter int FRAME_MAX_H = crn_pkg::FRAME_MAX_H_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    crn_in_if.sink    i_in,
    crn_out_if.source o_out,
    crn_cfg_if.sink   i_cfg
);
    import crn_pkg::*;

    t_cfg cfg;
    t_pos pos;
    t_tap tap;
    t_res res;
    logic out_v;
    logic adv;

    // Pipeline moves whenever the output slot is free or being emptied
    assign adv        = !out_v || o_out.ready;
    assign i_in.ready = adv;

    crn_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    crn_coord #(
        .FRAME_MAX_W (FRAME_MAX_W),
        .FRAME_MAX_H (FRAME_MAX_H)
    ) u_coord (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_take    (i_in.valid),
        .i_func    (i_in.func),
        .i_coord_x (i_in.coord_x),
        .i_coord_y (i_in.coord_y),
        .i_rgb     ({i_in.red, i_in.green, i_in.blue}),
        .i_cfg     (cfg),
        .o_pos     (pos)
    );

    crn_store #(
        .FRAME_MAX_W (FRAME_MAX_W),
        .FRAME_MAX_H (FRAME_MAX_H)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_pos     (pos),
        .i_frame_w (cfg.frame_w),
        .i_frame_h (cfg.frame_h),
        .o_tap     (tap)
    );

    crn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_tap   (tap),
        .o_res   (res),
        .o_valid (out_v)
    );

    assign o_out.valid      = out_v;
    assign o_out.out_x      = res.out_x;
    assign o_out.out_y      = res.out_y;
    assign o_out.red_norm   = res.red_norm;
    assign o_out.green_norm = res.green_norm;
    assign o_out.blue_norm  = res.blue_norm;

endmodule

`default_nettype wire

// ===== hw/rtl/crn_regs.sv =====
`default_nettype none

module crn_regs (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    crn_cfg_if.sink      i_cfg,
    output crn_pkg::t_cfg o_cfg
);
    import crn_pkg::*;

    t_cfg r_cfg;

    // Writes are taken every cycle
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_FRAME_W: begin
                    r_cfg.frame_w <= i_cfg.data[9:0];
                end
                REG_FRAME_H: begin
                    r_cfg.frame_h <= i_cfg.data[9:0];
                end
                REG_CROP_CX: begin
                    r_cfg.ccx <= $signed(i_cfg.data);
                end
                REG_CROP_CY: begin
                    r_cfg.ccy <= $signed(i_cfg.data);
                end
                REG_CROP_W: begin
                    r_cfg.cw <= i_cfg.data;
                end
                REG_CROP_H: begin
                    r_cfg.chh <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/crn_coord.sv =====
`default_nettype none

module crn_coord #(
    parameter int FRAME_MAX_W = crn_pkg::FRAME_MAX_W_DEF,
    parameter int FRAME_MAX_H = crn_pkg::FRAME_MAX_H_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_take,
    input  wire logic          i_func,
    input  wire logic [8:0]    i_coord_x,
    input  wire logic [8:0]    i_coord_y,
    input  wire logic [23:0]   i_rgb,
    input  wire crn_pkg::t_cfg i_cfg,
    output crn_pkg::t_pos      o_pos
);
    import crn_pkg::*;

    typedef struct packed {
        logic        v;
        logic        wr;
        logic [8:0]  cx;
        logic [8:0]  cy;
        logic [23:0] rgb;
    } t_meta;

    // Stage 1 registers
    t_meta              r1_meta;
    logic [28:0]        r1_px;
    logic [28:0]        r1_py;
    logic signed [21:0] r1_hx;
    logic signed [31:0] r1_by;
    // Stage 2 registers
    t_meta              r2_meta;
    logic [46:0]        r2_m;
    logic [28:0]        r2_px;
    logic signed [21:0] r2_hx;
    logic signed [24:0] r2_yf;
    // Stage 3 register
    t_pos               r_pos;

    logic               in_ok;
    logic signed [22:0] dx2;
    logic signed [21:0] hx_q;
    logic signed [21:0] n_hx;
    logic signed [31:0] n_by;
    logic signed [31:0] ny;
    logic signed [23:0] qy;
    logic               up_y;
    logic signed [24:0] n_yf;
    logic [21:0]        q3;
    logic [28:0]        rem29;
    logic [7:0]         rem;
    logic               up_x;
    logic [21:0]        qx;
    logic signed [23:0] xs;

    // Items dropped at entry: computes off the output grid, writes off the store
    always_comb begin
        if (i_func) begin
            in_ok = (int'(i_coord_x) < OUT_W) && (int'(i_coord_y) < OUT_H);
        end else begin
            in_ok = (int'(i_coord_x) < FRAME_MAX_W) && (int'(i_coord_y) < FRAME_MAX_H);
        end
    end

    // Stage 1: crop left edge rounded half to even, products with output coordinate
    always_comb begin
        dx2  = $signed({i_cfg.ccx[20], i_cfg.ccx, 1'b0}) - $signed({2'b00, i_cfg.cw});
        hx_q = dx2[22:1];
        n_hx = hx_q + $signed({21'b0, dx2[0] & hx_q[0]});
        n_by = $signed({{3{i_cfg.ccy[20]}}, i_cfg.ccy, 8'b0})
             - $signed({4'b0, i_cfg.chh, 7'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_meta.v <= 1'b0;
        end else if (i_adv) begin
            r1_meta.v <= i_take && in_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_meta.wr  <= !i_func;
            r1_meta.cx  <= i_coord_x;
            r1_meta.cy  <= i_coord_y;
            r1_meta.rgb <= i_rgb;
            r1_px       <= 29'(i_cfg.cw) * 29'(i_coord_x[7:0]);
            r1_py       <= 29'(i_cfg.chh) * 29'(i_coord_y[7:0]);
            r1_hx       <= n_hx;
            r1_by       <= n_by;
        end
    end

    // Stage 2: divide-by-3 reciprocal product, y rounded to 1/32 pixel
    always_comb begin
        ny   = r1_by + $signed({3'b0, r1_py});
        qy   = ny[31:8];
        up_y = (ny[7:0] > 8'd128) || ((ny[7:0] == 8'd128) && qy[0]);
        n_yf = $signed({qy[23], qy}) + 25'sd16 + $signed({24'b0, up_y});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_meta.v <= 1'b0;
        end else if (i_adv) begin
            r2_meta.v <= r1_meta.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_meta.wr  <= r1_meta.wr;
            r2_meta.cx  <= r1_meta.cx;
            r2_meta.cy  <= r1_meta.cy;
            r2_meta.rgb <= r1_meta.rgb;
            r2_m        <= 47'(r1_px[28:6]) * 47'(RECIP3);
            r2_px       <= r1_px;
            r2_hx       <= r1_hx;
            r2_yf       <= n_yf;
        end
    end

    // Stage 3: remainder of /192, round half to even, split into cell and fraction
    always_comb begin
        q3    = r2_m[RECIP3_SH +: 22];
        rem29 = r2_px - {q3, 7'b0} - 29'({q3, 6'b0});
        rem   = rem29[7:0];
        up_x  = (rem > 8'd96) || ((rem == 8'd96) && q3[0]);
        qx    = q3 + {21'b0, up_x};
        xs    = $signed({{2{r2_hx[21]}}, r2_hx}) + 24'sd16 + $signed({2'b00, qx});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos.v <= 1'b0;
        end else if (i_adv) begin
            r_pos.v <= r2_meta.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pos.wr  <= r2_meta.wr;
            r_pos.cx  <= r2_meta.cx;
            r_pos.cy  <= r2_meta.cy;
            r_pos.rgb <= r2_meta.rgb;
            r_pos.x0  <= $signed({{2{xs[23]}}, xs[23:10]});
            r_pos.fx  <= xs[9:5];
            r_pos.y0  <= $signed({r2_yf[24], r2_yf[24:10]});
            r_pos.fy  <= r2_yf[9:5];
        end
    end

    assign o_pos = r_pos;

endmodule

`default_nettype wire

// ===== hw/rtl/crn_store.sv =====
`default_nettype none

module crn_store #(
    parameter int FRAME_MAX_W = crn_pkg::FRAME_MAX_W_DEF,
    parameter int FRAME_MAX_H = crn_pkg::FRAME_MAX_H_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire crn_pkg::t_pos i_pos,
    input  wire logic [9:0]    i_frame_w,
    input  wire logic [9:0]    i_frame_h,
    output crn_pkg::t_tap      o_tap
);
    import crn_pkg::*;

    // Four banks split by x and y parity, so any 2x2 block hits each bank once
    localparam int XB         = $clog2(FRAME_MAX_W) - 1;
    localparam int YB         = $clog2(FRAME_MAX_H) - 1;
    localparam int AW         = XB + YB;
    localparam int BANK_DEPTH = 1 << AW;

    logic [11:0]   ew;
    logic [11:0]   eh;
    logic [1:0]    wbank;
    logic [XB:0]   wxe;
    logic [YB:0]   wye;
    logic [AW-1:0] waddr;
    logic [10:0]   n_w   [4];
    logic [AW-1:0] raddr [4];
    logic [23:0]   rd    [4];

    logic          r_v;
    logic [7:0]    r_ox;
    logic [7:0]    r_oy;
    logic [10:0]   r_w   [4];

    // Effective frame size, limited to the store
    always_comb begin
        ew = (int'(i_frame_w) < FRAME_MAX_W) ? 12'(i_frame_w) : 12'(FRAME_MAX_W);
        eh = (int'(i_frame_h) < FRAME_MAX_H) ? 12'(i_frame_h) : 12'(FRAME_MAX_H);
    end

    // Write address
    always_comb begin
        wbank = {i_pos.cy[0], i_pos.cx[0]};
        wxe   = (XB + 1)'(i_pos.cx);
        wye   = (YB + 1)'(i_pos.cy);
        waddr = {wye[YB:1], wxe[XB:1]};
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PX = 1'(b % 2);
        localparam logic PY = 1'(b / 2);

        logic signed [16:0] x0e;
        logic signed [16:0] y0e;
        logic signed [16:0] xx;
        logic signed [16:0] yy;
        logic               dxn;
        logic               dyn;
        logic               ok;
        logic [5:0]         wxv;
        logic [5:0]         wyv;
        logic [11:0]        wprod;
        logic               we;
        logic [23:0]        r_mem [BANK_DEPTH];
        logic [23:0]        r_rd;
        logic               r_ok;

        // Neighbour of this bank's parity, its weight and range check
        always_comb begin
            x0e   = {i_pos.x0[15], i_pos.x0};
            y0e   = {i_pos.y0[15], i_pos.y0};
            dxn   = (PX != i_pos.x0[0]);
            dyn   = (PY != i_pos.y0[0]);
            xx    = dxn ? x0e + 17'sd1 : x0e;
            yy    = dyn ? y0e + 17'sd1 : y0e;
            ok    = !xx[16] && (xx < $signed({5'b0, ew}))
                 && !yy[16] && (yy < $signed({5'b0, eh}));
            wxv   = dxn ? {1'b0, i_pos.fx} : 6'd32 - {1'b0, i_pos.fx};
            wyv   = dyn ? {1'b0, i_pos.fy} : 6'd32 - {1'b0, i_pos.fy};
            wprod = 12'(wxv) * 12'(wyv);
            we    = i_adv && i_pos.v && i_pos.wr && (wbank == 2'(b));
        end

        assign n_w[b]   = ok ? wprod[10:0] : 11'd0;
        assign raddr[b] = {yy[YB:1], xx[XB:1]};
        // Neighbours off the frame contribute zero
        assign rd[b]    = r_ok ? r_rd : 24'd0;

        // Bank memory, read data registered
        always_ff @(posedge i_clk) begin
            if (we) begin
                r_mem[waddr] <= i_pos.rgb;
            end
            if (i_adv) begin
                r_rd <= r_mem[raddr[b]];
                r_ok <= ok;
            end
        end
    end

    // Sideband aligned with the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_adv) begin
            r_v <= i_pos.v && !i_pos.wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ox <= i_pos.cx[7:0];
            r_oy <= i_pos.cy[7:0];
            for (int b = 0; b < 4; b++) begin
                r_w[b] <= n_w[b];
            end
        end
    end

    always_comb begin
        o_tap.v  = r_v;
        o_tap.ox = r_ox;
        o_tap.oy = r_oy;
        for (int b = 0; b < 4; b++) begin
            o_tap.w[b]   = r_w[b];
            o_tap.pix[b] = rd[b];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/crn_norm.sv =====
`default_nettype none

module crn_norm (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire crn_pkg::t_tap i_tap,
    output crn_pkg::t_res      o_res,
    output logic               o_valid
);
    import crn_pkg::*;

    logic [19:0] acc [3];
    logic [19:0] rnd [3];

    logic        r6_v;
    logic [7:0]  r6_ox;
    logic [7:0]  r6_oy;
    logic [7:0]  r6_val [3];

    t_res        r_res;
    logic        r_out_v;

    // Weighted 2x2 sum per channel, rounded back to 8 bits
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            acc[ch] = '0;
            for (int b = 0; b < 4; b++) begin
                acc[ch] = acc[ch]
                        + 20'(i_tap.pix[b][(2 - ch) * 8 +: 8]) * 20'(i_tap.w[b]);
            end
            rnd[ch] = acc[ch] + 20'd512;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (i_adv) begin
            r6_v <= i_tap.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r6_ox <= i_tap.ox;
            r6_oy <= i_tap.oy;
            for (int ch = 0; ch < 3; ch++) begin
                r6_val[ch] <= rnd[ch][17:10];
            end
        end
    end

    // Output register: mean/deviation tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_adv) begin
            r_out_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res.out_x      <= r6_ox;
            r_res.out_y      <= r6_oy;
            r_res.red_norm   <= NORM_LUT_R[r6_val[0]];
            r_res.green_norm <= NORM_LUT_G[r6_val[1]];
            r_res.blue_norm  <= NORM_LUT_B[r6_val[2]];
        end
    end

    assign o_res   = r_res;
    assign o_valid = r_out_v;

endmodule

`default_nettype wire

// ===== hw/rtl/crn_checker.sv =====
`default_nettype none

module crn_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        in_func,
    input wire logic [8:0]  in_x,
    input wire logic [8:0]  in_y,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  out_x,
    input wire logic [15:0] out_r
);
    import crn_pkg::*;

    // Compute beats in flight (pipeline plus output register)
    localparam logic [3:0] MAX_INFLIGHT = 4'd6;

    logic [3:0] r_cnt;
    logic       inc;
    logic       dec;

    assign inc = in_valid && in_ready && in_func
              && (int'(in_x) < OUT_W) && (int'(in_y) < OUT_H);
    assign dec = out_valid && out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 4'(inc) - 4'(dec);
        end
    end

    // Held result keeps its beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_r))
        else $error("result changed while stalled");

    // No result without an earlier accepted compute
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> r_cnt != 4'd0)
        else $error("result without a matching compute");

    // Pipeline never holds more than its depth
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_INFLIGHT)
        else $error("too many computes in flight");

    // Input stalls only behind a blocked result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without back-pressure");

endmodule

bind bilinear_crop_resize_normalize_top crn_checker u_crn_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .in_func   (i_in.func),
    .in_x      (i_in.coord_x),
    .in_y      (i_in.coord_y),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_x     (o_out.out_x),
    .out_r     (o_out.red_norm)
);

`default_nettype wire

// ===== tb/crn_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crn_tb_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    crn_in_if         i_in,
    crn_out_if        i_out,
    crn_cfg_if        i_cfg,
    output int        o_mismatches,
    output int        o_pending,
    output int        o_checked
);
    import crn_pkg::*;

    localparam int STORE_W = FRAME_MAX_W_DEF;
    localparam int STORE_H = FRAME_MAX_H_DEF;

    // Shadow of the block's registers and frame store
    longint      geo_fw, geo_fh, geo_ccx, geo_ccy, geo_cw, geo_ch;
    logic [23:0] pix_mem [STORE_W*STORE_H];
    t_res        pixel_q [$];

    function automatic longint fdiv(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) begin
            q--;
        end
        return q;
    endfunction

    // Nearest, ties to even
    function automatic longint rnd_even(input longint n, input longint d);
        longint q;
        longint r;
        q = fdiv(n, d);
        r = n - q * d;
        if (2 * r > d || (2 * r == d && q[0])) begin
            q++;
        end
        return q;
    endfunction

    function automatic logic signed [15:0] to_q3_12(input longint v, input longint mu,
                                                    input longint sd);
        longint n;
        longint q;
        n = 4096 * (1000 * v - mu);
        q = (n >= 0) ? (2 * n + sd) / (2 * sd) : -((-2 * n + sd) / (2 * sd));
        if (q > 32767) begin
            q = 32767;
        end
        if (q < -32768) begin
            q = -32768;
        end
        return 16'(q);
    endfunction

    // Bilinear sample and normalise one output pixel
    function automatic t_res resample_pixel(input logic [8:0] ox, input logic [8:0] oy);
        t_res   r;
        longint fxp, fyp, x0, y0, fx, fy, ew, eh, xx, yy, w;
        longint acc [3];
        logic [23:0] p;
        fxp = fdiv(rnd_even(2 * geo_ccx - geo_cw, 2) + 16
                   + rnd_even(geo_cw * longint'(ox), 192), 32);
        fyp = fdiv(rnd_even(256 * geo_ccy - 128 * geo_ch + geo_ch * longint'(oy), 256)
                   + 16, 32);
        x0 = fdiv(fxp, 32);
        y0 = fdiv(fyp, 32);
        fx = fxp - 32 * x0;
        fy = fyp - 32 * y0;
        ew = (geo_fw < STORE_W) ? geo_fw : STORE_W;
        eh = (geo_fh < STORE_H) ? geo_fh : STORE_H;
        acc = '{0, 0, 0};
        for (int dy = 0; dy < 2; dy++) begin
            for (int dx = 0; dx < 2; dx++) begin
                xx = x0 + dx;
                yy = y0 + dy;
                if (xx >= 0 && xx < ew && yy >= 0 && yy < eh) begin
                    p = pix_mem[yy * STORE_W + xx];
                    w = (dx ? fx : 32 - fx) * (dy ? fy : 32 - fy);
                    acc[0] += longint'(p[23:16]) * w;
                    acc[1] += longint'(p[15:8]) * w;
                    acc[2] += longint'(p[7:0]) * w;
                end
            end
        end
        r.out_x      = ox[7:0];
        r.out_y      = oy[7:0];
        r.red_norm   = to_q3_12((acc[0] + 512) >>> 10, MEAN_R, SD_R);
        r.green_norm = to_q3_12((acc[1] + 512) >>> 10, MEAN_G, SD_G);
        r.blue_norm  = to_q3_12((acc[2] + 512) >>> 10, MEAN_B, SD_B);
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        o_mismatches++;
    endtask

    initial begin
        o_mismatches = 0;
        o_checked    = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            geo_fw  = CFG_RESET.frame_w;
            geo_fh  = CFG_RESET.frame_h;
            geo_ccx = CFG_RESET.ccx;
            geo_ccy = CFG_RESET.ccy;
            geo_cw  = CFG_RESET.cw;
            geo_ch  = CFG_RESET.chh;
            pixel_q.delete();
        end else begin
            // Result beat against the oldest expectation
            if (i_out.valid && i_out.ready) begin
                if (pixel_q.size() == 0) begin
                    report("unexpected result beat, out_x", i_out.out_x, -1);
                end else begin
                    want = pixel_q.pop_front();
                    o_checked++;
                    if (i_out.out_x != want.out_x)
                        report("out_x", i_out.out_x, want.out_x);
                    if (i_out.out_y != want.out_y)
                        report("out_y", i_out.out_y, want.out_y);
                    if (i_out.red_norm != want.red_norm)
                        report("red_norm", i_out.red_norm, want.red_norm);
                    if (i_out.green_norm != want.green_norm)
                        report("green_norm", i_out.green_norm, want.green_norm);
                    if (i_out.blue_norm != want.blue_norm)
                        report("blue_norm", i_out.blue_norm, want.blue_norm);
                end
            end
            // Input beat: store write or output pixel
            if (i_in.valid && i_in.ready) begin
                if (!i_in.func) begin
                    pix_mem[int'(i_in.coord_y) * STORE_W + int'(i_in.coord_x)] =
                        {i_in.red, i_in.green, i_in.blue};
                end else if (i_in.coord_x < OUT_W && i_in.coord_y < OUT_H) begin
                    pixel_q.insert(pixel_q.size(),
                                   resample_pixel(i_in.coord_x, i_in.coord_y));
                end
            end
            // Register write
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_FRAME_W: geo_fw  = i_cfg.data[9:0];
                    REG_FRAME_H: geo_fh  = i_cfg.data[9:0];
                    REG_CROP_CX: geo_ccx = longint'(signed'(i_cfg.data));
                    REG_CROP_CY: geo_ccy = longint'(signed'(i_cfg.data));
                    REG_CROP_W:  geo_cw  = i_cfg.data;
                    REG_CROP_H:  geo_ch  = i_cfg.data;
                    default: ;
                endcase
            end
        end
        o_pending = pixel_q.size();
    end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import crn_pkg::*;

    localparam int PHASES = 7;
    localparam int PATCH  = 16;

    logic i_clk;
    logic i_rst_n;
    int   mismatches, pending, checked;
    logic quiet;      // no idling on either side
    logic hold_req;   // ask the result side for a long stall
    int   items_sent;

    crn_in_if  in_ch ();
    crn_out_if out_ch ();
    crn_cfg_if cfg_ch ();

    bilinear_crop_resize_normalize_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    crn_tb_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    // Crop geometry per phase: frame w/h, centre x/y, crop w/h (1/1024 px).
    // Every phase keeps sampled neighbours inside the written patch or off the frame.
    longint geo [PHASES][6] = '{
        '{16,   16,   8192,     8192,     16384,   16384},   // upscale over patch
        '{1023, 1023, 7168,     7168,     14336,   14336},   // frame clamps to store
        '{0,    0,    1048575,  -1048576, 2097151, 2097151}, // empty frame
        '{16,   5,    -3072,    2048,     40960,   9000},    // crop hangs off edges
        '{16,   16,   5632,     5632,     0,       0},       // degenerate crop
        '{512,  512,  -1048576, 1048575,  1000,    1},       // crop far outside
        '{1,    1,    512,      512,      1024,    1024}     // single pixel frame
    };

    task automatic send_beat(input logic f, input logic [8:0] x, input logic [8:0] y,
                             input logic [23:0] rgb);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.func    <= f;
        in_ch.coord_x <= x;
        in_ch.coord_y <= y;
        in_ch.red     <= rgb[23:16];
        in_ch.green   <= rgb[15:8];
        in_ch.blue    <= rgb[7:0];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Stop offering and wait until every result has come out
    task automatic drain;
        int guard;
        in_ch.valid <= 1'b0;
        guard = 0;
        @(posedge i_clk);
        while (pending != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input longint value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_beat;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 84) begin
            send_beat(1'b1, 9'($urandom_range(0, OUT_W - 1)),
                      9'($urandom_range(0, OUT_H - 1)), 24'($urandom));
        end else if (pick < 89) begin
            // compute outside the output grid
            if (pick[0]) begin
                send_beat(1'b1, 9'($urandom_range(OUT_W, 511)), 9'($urandom), 24'($urandom));
            end else begin
                send_beat(1'b1, 9'($urandom), 9'($urandom_range(OUT_H, 511)), 24'($urandom));
            end
        end else if (pick < 95) begin
            send_beat(1'b0, 9'($urandom_range(0, PATCH - 1)),
                      9'($urandom_range(0, PATCH - 1)), 24'($urandom));
        end else begin
            send_beat(1'b0, 9'($urandom), 9'($urandom), 24'($urandom));
        end
    endtask

    // Result side: random stall per beat, plus one long hold on request
    initial begin
        int w;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end
            w = quiet ? 0 : $urandom_range(0, 3);
            if (w > 0) begin
                out_ch.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Stimulus
    initial begin
        in_ch.valid   = 1'b0;
        in_ch.func    = 1'b0;
        in_ch.coord_x = '0;
        in_ch.coord_y = '0;
        in_ch.red     = '0;
        in_ch.green   = '0;
        in_ch.blue    = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = REG_FRAME_W;
        cfg_ch.data   = '0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        items_sent    = 0;
        i_rst_n       = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the patch; the first two pixels of the top row at the byte extremes
        for (int y = 0; y < PATCH; y++) begin
            for (int x = 0; x < PATCH; x++) begin
                send_beat(1'b0, 9'(x), 9'(y),
                          (x == 0 && y == 0) ? 24'hFFFFFF :
                          (x == 1 && y == 0) ? 24'h000000 : 24'($urandom));
            end
        end
        // Write at the far corner of the store
        send_beat(1'b0, 9'd511, 9'd511, 24'hFFFFFF);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(REG_FRAME_W, geo[ph][0]);
            write_reg(REG_FRAME_H, geo[ph][1]);
            write_reg(REG_CROP_CX, geo[ph][2]);
            write_reg(REG_CROP_CY, geo[ph][3]);
            write_reg(REG_CROP_W,  geo[ph][4]);
            write_reg(REG_CROP_H,  geo[ph][5]);
            quiet = ph[0];

            if (ph == 0) begin
                // corners of the output grid, ignored computes past it, two writes, two inner computes
                send_beat(1'b1, 9'd0,   9'd0,   24'h0);
                send_beat(1'b1, 9'd191, 9'd0,   24'h0);
                send_beat(1'b1, 9'd0,   9'd255, 24'h0);
                send_beat(1'b1, 9'd191, 9'd255, 24'h0);
                send_beat(1'b1, 9'd192, 9'd0,   24'h0);
                send_beat(1'b1, 9'd0,   9'd256, 24'h0);
                send_beat(1'b1, 9'd511, 9'd511, 24'h0);
                send_beat(1'b0, 9'd2,   9'd2,   24'h000000);
                send_beat(1'b0, 9'd3,   9'd2,   24'hFFFFFF);
                send_beat(1'b1, 9'd24,  9'd32,  24'h0);
                send_beat(1'b1, 9'd36,  9'd40,  24'h0);
                // long stall downstream while items keep coming
                hold_req = 1'b1;
                repeat (40) random_beat();
            end else begin
                send_beat(1'b1, 9'd0,   9'd0,   24'h0);
                send_beat(1'b1, 9'd191, 9'd255, 24'h0);
            end
            repeat (83) random_beat();
            drain();
        end

        $display("run: %0d input beats over %0d crop settings, %0d pixels checked",
                 items_sent, PHASES, checked);
        $display("run: covered empty, single-pixel and clamped frames, off-frame crops");
        if (mismatches == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
